// ===== hw/rtl/tlpw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlpw_pkg: shared definitions for the two-level page table walker
// Holds the item codes, descriptor type codes, result kinds, fixed table
// geometry and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tlpw_pkg;

  // Item action codes.
  localparam logic [1:0] ACT_WR_L1   = 2'd0;
  localparam logic [1:0] ACT_WR_POOL = 2'd1;
  localparam logic [1:0] ACT_XLATE   = 2'd2;

  // First-level descriptor type codes (bits 1:0).
  localparam logic [1:0] L1_COARSE  = 2'd1;
  localparam logic [1:0] L1_SECTION = 2'd2;

  // Coarse descriptor type code that faults.
  localparam logic [1:0] L2_FAULT = 2'd0;

  // Result kinds.
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_SECTION = 3'd1;
  localparam logic [2:0] KIND_SUPER   = 3'd2;
  localparam logic [2:0] KIND_LARGE   = 3'd3;
  localparam logic [2:0] KIND_SMALL   = 3'd4;

  localparam logic [31:0] FAULT_ADDR = 32'hffff_ffff;

  // Fixed geometry.
  localparam int L1_DEPTH        = 4096;
  localparam int COARSE_ENTRIES  = 256;
  localparam int INDEX_W         = 14;
  // Pool tables reachable through a 14-bit write index.
  localparam int MAX_POOL_TABLES = (1 << INDEX_W) / COARSE_ENTRIES;
  // Width of the coarse table number field, descriptor bits 31..10.
  localparam int TBL_NUM_W       = 22;
  // Reciprocal scaling for the modulo reduction of the table number.
  localparam int RECIP_SHIFT     = 22;
  localparam int MUL_W           = TBL_NUM_W + RECIP_SHIFT + 1;
  localparam int QM_W            = TBL_NUM_W + 13;

  typedef struct packed {
    logic clr_en;      // clearing pass writes zero to both tables
    logic accept;      // an item transfer happens this cycle
    logic l1_eval;     // first-level descriptor is in its read register
    logic mul_step;    // table number times reciprocal
    logic qm_step;     // quotient estimate times table count
    logic sub_step;    // partial remainder
    logic pool_issue;  // final remainder, pool read
    logic pool_eval;   // coarse descriptor is in its read register
  } tlpw_cmd_t;

  typedef struct packed {
    logic clr_last;    // last word of the clearing pass
    logic xlate;       // offered item is a translation
    logic coarse;      // first-level descriptor points to a coarse table
  } tlpw_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tlpw_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlpw_ctrl: sequencing controller for the page table walker
// Runs the clearing pass after reset, accepts items and steps a translation
// through the first-level read, the modulo reduction and the pool read.
// ----------------------------------------------------------------------------
module tlpw_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  tlpw_pkg::tlpw_stat_t  stat,
  output tlpw_pkg::tlpw_cmd_t   cmd
);
  import tlpw_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_L1    = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_QM    = 7'b0010000,
    S_REM   = 7'b0100000,
    S_POOL  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start && stat.xlate) state_next = S_L1;
      end
      S_L1: begin
        state_next = stat.coarse ? S_MUL : S_IDLE;
      end
      S_MUL:   state_next = S_QM;
      S_QM:    state_next = S_REM;
      S_REM:   state_next = S_POOL;
      S_POOL:  state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.clr_en     = (state == S_CLEAR);
    cmd.accept     = (state == S_IDLE) && start;
    cmd.l1_eval    = (state == S_L1);
    cmd.mul_step   = (state == S_L1) && stat.coarse;
    cmd.qm_step    = (state == S_MUL);
    cmd.sub_step   = (state == S_QM);
    cmd.pool_issue = (state == S_REM);
    cmd.pool_eval  = (state == S_POOL);
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

// ===== hw/rtl/tlpw_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlpw_dp: datapath of the page table walker
// Holds the first-level table and the coarse table pool, the clearing
// counter, the reciprocal modulo pipeline and the result registers.
// ----------------------------------------------------------------------------
module tlpw_dp #(
  parameter int COARSE_TABLES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tlpw_pkg::tlpw_cmd_t   cmd,
  output tlpw_pkg::tlpw_stat_t  stat,
  input  logic [1:0]            action,
  input  logic [13:0]           table_index,
  input  logic [31:0]           entry_data,
  input  logic [31:0]           virtual_address,
  output logic                  done,
  output logic [31:0]           physical_address,
  output logic                  mapped,
  output logic [2:0]            mapping_kind
);
  import tlpw_pkg::*;

  // Only the first tables of the pool can ever be written; the rest read zero.
  localparam int PHYS_TABLES = (COARSE_TABLES < MAX_POOL_TABLES) ?
                               COARSE_TABLES : MAX_POOL_TABLES;
  localparam int POOL_DEPTH  = PHYS_TABLES * COARSE_ENTRIES;
  localparam int PAW         = $clog2(POOL_DEPTH);
  localparam int RW          = $clog2(2 * COARSE_TABLES);
  localparam int CLR_COUNT   = (L1_DEPTH > POOL_DEPTH) ? L1_DEPTH : POOL_DEPTH;
  localparam int CW          = $clog2(CLR_COUNT);
  localparam int RECIP       = (1 << RECIP_SHIFT) / COARSE_TABLES;

  logic [31:0]          l1_mem   [L1_DEPTH];
  logic [31:0]          pool_mem [POOL_DEPTH];

  logic [CW-1:0]        clr_cnt;
  logic [31:0]          l1_q;
  logic [31:0]          pool_q;
  logic [31:0]          va_q;
  logic [MUL_W-1:0]     mul_q;
  logic [QM_W-1:0]      qm_q;
  logic [RW-1:0]        rem_q;
  logic                 in_pool_q;

  logic                 l1_we;
  logic [11:0]          l1_wa;
  logic [31:0]          mem_wd;
  logic                 pool_we;
  logic [PAW-1:0]       pool_wa;
  logic [PAW-1:0]       pool_ra;
  logic [QM_W-1:0]      rem_full;
  logic [RW-1:0]        tbl;
  logic                 tbl_in_pool;
  logic [31:0]          desc;
  logic [11:0]          super_hi;
  logic                 res_load;
  logic [31:0]          res_pa;
  logic                 res_mapped;
  logic [2:0]           res_kind;

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign stat.clr_last = (clr_cnt == CW'(CLR_COUNT - 1));
  assign stat.xlate    = (action == ACT_XLATE);
  assign stat.coarse   = (l1_q[1:0] == L1_COARSE);

  // Write ports are shared by the clearing pass and the write items.
  assign mem_wd  = cmd.clr_en ? 32'd0 : entry_data;
  assign l1_we   = cmd.clr_en || (cmd.accept && action == ACT_WR_L1);
  assign l1_wa   = cmd.clr_en ? clr_cnt[11:0] : table_index[11:0];
  assign pool_we = cmd.clr_en ||
                   (cmd.accept && action == ACT_WR_POOL &&
                    (15'(table_index) < 15'(POOL_DEPTH)));
  assign pool_wa = cmd.clr_en ? PAW'(clr_cnt) : PAW'(table_index);

  always_ff @(posedge clk) begin
    if (l1_we) l1_mem[l1_wa] <= mem_wd;
    if (cmd.accept) l1_q <= l1_mem[virtual_address[31:20]];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) va_q <= virtual_address;
  end

  // Table number modulo the table count: reciprocal estimate, then one
  // correction step, since the estimated quotient is at most one short.
  assign rem_full = QM_W'(l1_q[31:10]) - qm_q;
  assign tbl      = (rem_q >= RW'(COARSE_TABLES)) ? rem_q - RW'(COARSE_TABLES) : rem_q;
  assign tbl_in_pool = (tbl < RW'(PHYS_TABLES));
  assign pool_ra  = PAW'({tbl, va_q[19:12]});

  always_ff @(posedge clk) begin
    if (cmd.mul_step) mul_q <= MUL_W'(l1_q[31:10]) * MUL_W'(RECIP);
    if (cmd.qm_step)  qm_q  <= QM_W'(mul_q[RECIP_SHIFT +: TBL_NUM_W]) * QM_W'(COARSE_TABLES);
    if (cmd.sub_step) rem_q <= rem_full[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (pool_we) pool_mem[pool_wa] <= mem_wd;
    if (cmd.pool_issue) begin
      in_pool_q <= tbl_in_pool;
      if (tbl_in_pool) pool_q <= pool_mem[pool_ra];
    end
  end

  assign desc     = in_pool_q ? pool_q : 32'd0;
  assign super_hi = l1_q[31:20] + {8'd0, va_q[23:20]};

  // Result selection.
  assign res_load = (cmd.accept && !stat.xlate) ||
                    (cmd.l1_eval && !stat.coarse) || cmd.pool_eval;

  always_comb begin
    res_pa     = FAULT_ADDR;
    res_mapped = 1'b0;
    res_kind   = KIND_NONE;
    if (cmd.accept) begin
      res_pa = 32'd0;
    end else if (cmd.l1_eval) begin
      if (l1_q[1:0] == L1_SECTION) begin
        res_mapped = 1'b1;
        if (l1_q[18]) begin
          res_pa   = {super_hi, va_q[19:0]};
          res_kind = KIND_SUPER;
        end else begin
          res_pa   = {l1_q[31:20], va_q[19:0]};
          res_kind = KIND_SECTION;
        end
      end
    end else if (desc[1:0] != L2_FAULT) begin
      res_mapped = 1'b1;
      if (desc[1]) begin
        res_pa   = {desc[31:12], va_q[11:0]};
        res_kind = KIND_SMALL;
      end else begin
        res_pa   = {desc[31:16], va_q[15:0]};
        res_kind = KIND_LARGE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      physical_address <= res_pa;
      mapped           <= res_mapped;
      mapping_kind     <= res_kind;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/two_level_page_table_walk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_page_table_walk: short-descriptor style two-level address walker
// Top level joining the sequencing controller and the table datapath.
// ----------------------------------------------------------------------------
// Usage. An item is offered on start with action, table_index, entry_data
// and virtual_address, and its transfer happens at a clock edge where start
// is high and busy is low. Each item produces exactly one result, shown on
// physical_address, mapped and mapping_kind for one cycle while done is high.
// The receiver cannot stall; it must take the result in that cycle.
// Path from the transfer edge to the done cycle:
//   - table writes and unused actions: the result is registered straight
//     from the transfer; the block is ready again in the very next cycle, so writes run at one per cycle;
//   - translations resolved at the first level (fault, section,
//     supersection): resolved after the registered first-level read;
//   - coarse translations: the first-level read, then a
//     three-step reciprocal reduction of the table number modulo
//     COARSE_TABLES (multiply, multiply, subtract and correct) and the
//     registered pool read.
// Only one item is in flight at a time; busy stays high until its result.
// Reset: after rst, the block sweeps both tables to zero, one word per
// cycle, over max(4096, min(COARSE_TABLES, 64) * 256) words (16384 by
// default) with busy high. Pool words beyond the 14-bit write index range
// are not stored and always read as zero.
// ----------------------------------------------------------------------------
module two_level_page_table_walk #(
  parameter int COARSE_TABLES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [13:0] table_index,
  input  logic [31:0] entry_data,
  input  logic [31:0] virtual_address,
  output logic        done,
  output logic [31:0] physical_address,
  output logic        mapped,
  output logic [2:0]  mapping_kind
);
  import tlpw_pkg::*;

  tlpw_cmd_t  cmd;
  tlpw_stat_t stat;

  // The controller owns the sequence; all table and arithmetic state is
  // in the datapath.
  tlpw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  tlpw_dp #(
    .COARSE_TABLES (COARSE_TABLES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .action           (action),
    .table_index      (table_index),
    .entry_data       (entry_data),
    .virtual_address  (virtual_address),
    .done             (done),
    .physical_address (physical_address),
    .mapped           (mapped),
    .mapping_kind     (mapping_kind)
  );

  // A result only appears once the walk has finished.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while a walk is still in progress");

  // Every transfer is either answered next cycle or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("transfer neither answered nor in progress");

  // The mapped flag agrees with the mapping kind.
  a_mapped_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> (mapped == (mapping_kind != KIND_NONE)))
    else $error("mapped flag disagrees with mapping kind");

  // Unmapped results are either a zero answer to a non-translation item or a fault address.
  a_unmapped_addr: assert property (@(posedge clk) disable iff (rst)
    (done && !mapped) |-> (physical_address == 32'd0 ||
                           physical_address == FAULT_ADDR))
    else $error("unmapped result with a translated address");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for two_level_page_table_walk
// Drives table writes, pool writes, translations and the unused action
// through the start/busy handshake. A scoreboard keeps shadow copies of both
// tables, predicts every result and compares each done strobe with the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import tlpw_pkg::*;

  // The block is built with the default pool of 64 coarse tables.
  localparam int          POOL_TABLES = 64;
  localparam int          POOL_WORDS  = POOL_TABLES * COARSE_ENTRIES;
  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam int          SUPER_BIT   = 18;
  // The limit covers the clearing pass and then every item with the sender's
  // gaps, and leaves a wide margin.
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          PHASE_ITEMS = 630;
  localparam int          MAX_REPORTS = 100;

  typedef struct packed {
    logic [31:0] phys;
    logic        ok;
    logic [2:0]  kind;
  } walk_result_t;

  // Scoreboard: shadow tables, predicted results in order, failure count.
  class walk_scoreboard;
    bit [31:0]    l1_shadow [L1_DEPTH];
    bit [31:0]    pool_shadow [POOL_WORDS];
    walk_result_t expected_q [$];
    int           failures;

    // Update the shadow state for one accepted item and queue its result.
    function void note_item(logic [1:0] act, logic [13:0] idx, logic [31:0] data,
                            logic [31:0] va);
      walk_result_t res;
      logic [31:0]  desc;
      logic [31:0]  leaf;
      int unsigned  word;
      res = '{phys: 32'd0, ok: 1'b0, kind: KIND_NONE};
      case (act)
        ACT_WR_L1: begin
          l1_shadow[idx[11:0]] = data;
        end
        ACT_WR_POOL: begin
          if (idx < POOL_WORDS) pool_shadow[idx] = data;
        end
        ACT_XLATE: begin
          desc = l1_shadow[va[31:20]];
          res = '{phys: FAULT_ADDR, ok: 1'b0, kind: KIND_NONE};
          case (desc[1:0])
            L1_SECTION: begin
              if (desc[SUPER_BIT])
                res = '{phys: (desc & 32'hfff0_0000) + (va & 32'h00ff_ffff),
                        ok: 1'b1, kind: KIND_SUPER};
              else
                res = '{phys: (desc & 32'hfff0_0000) + (va & 32'h000f_ffff),
                        ok: 1'b1, kind: KIND_SECTION};
            end
            L1_COARSE: begin
              // Table number is descriptor bits 31..10, reduced modulo the pool.
              word = (desc[31:10] % POOL_TABLES) * COARSE_ENTRIES + va[19:12];
              leaf = (word < POOL_WORDS) ? pool_shadow[word] : 32'd0;
              if (leaf[1:0] != L2_FAULT) begin
                if (leaf[1])
                  res = '{phys: (leaf & 32'hffff_f000) + (va & 32'h0000_0fff),
                          ok: 1'b1, kind: KIND_SMALL};
                else
                  res = '{phys: (leaf & 32'hffff_0000) + (va & 32'h0000_ffff),
                          ok: 1'b1, kind: KIND_LARGE};
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [31:0] phys, logic ok, logic [2:0] kind);
      walk_result_t exp_res;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) $error("result strobe with no item outstanding");
        return;
      end
      exp_res = expected_q.pop_front();
      if (phys !== exp_res.phys) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $error("physical_address: expected %h, got %h", exp_res.phys, phys);
      end
      if (ok !== exp_res.ok) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $error("mapped: expected %0d, got %0d", exp_res.ok, ok);
      end
      if (kind !== exp_res.kind) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $error("mapping_kind: expected %0d, got %0d", exp_res.kind, kind);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action = ACT_WR_L1;
  logic [13:0] table_index = '0;
  logic [31:0] entry_data = '0;
  logic [31:0] virtual_address = '0;
  logic        done;
  logic [31:0] physical_address;
  logic        mapped;
  logic [2:0]  mapping_kind;

  walk_scoreboard walk_sb = new();
  int             cycle_count = 0;
  int unsigned    idle_pct = 12;

  // Small sets of "hot" first-level slots, pool tables and pool words. Random
  // writes and translations mostly aim at them so that walks hit real
  // descriptors instead of faulting on empty entries.
  logic [11:0] hot_l1 [8];
  logic [5:0]  hot_tbl [4];
  logic [7:0]  hot_word [8];

  two_level_page_table_walk #(
    .COARSE_TABLES(POOL_TABLES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .table_index(table_index),
    .entry_data(entry_data),
    .virtual_address(virtual_address),
    .done(done),
    .physical_address(physical_address),
    .mapped(mapped),
    .mapping_kind(mapping_kind)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Everything sampled here holds its value from before the edge, since the
  // block and the drivers update only through nonblocking assignments. The
  // result check runs before the new item is noted; a result never belongs to
  // an item transferred at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) walk_sb.check_result(physical_address, mapped, mapping_kind);
      if (start && !busy) walk_sb.note_item(action, table_index, entry_data, virtual_address);
    end
  end

  // Watchdog on the whole run, clearing pass included.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offers one item and returns at the edge where its transfer happens. The
  // sender may first hold start low for a random number of cycles.
  task automatic send_item(input logic [1:0] act, input logic [13:0] idx,
                           input logic [31:0] data, input logic [31:0] va);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    action          <= act;
    table_index     <= idx;
    entry_data      <= data;
    virtual_address <= va;
    do @(posedge clk); while (busy);
  endtask

  // One random item. Most are aimed at the hot sets; the rest are noise that
  // can land anywhere in the tables or in the address space.
  task automatic send_random_item();
    int unsigned pick;
    logic [1:0]  act;
    logic [13:0] idx;
    logic [31:0] data;
    logic [31:0] va;
    pick = $urandom_range(99);
    idx  = 14'($urandom);
    data = $urandom;
    va   = $urandom;
    if (pick < 18) begin
      act = ACT_WR_L1;
      if ($urandom_range(99) < 80) idx[11:0] = hot_l1[$urandom_range(7)];
      // Lean toward coarse descriptors, which take the longest walk.
      if ($urandom_range(99) < 40) data[1:0] = L1_COARSE;
      if (data[1:0] == L1_COARSE && $urandom_range(99) < 85)
        data[15:10] = hot_tbl[$urandom_range(3)];
    end else if (pick < 40) begin
      act = ACT_WR_POOL;
      if ($urandom_range(99) < 80)
        idx = {hot_tbl[$urandom_range(3)], hot_word[$urandom_range(7)]};
    end else if (pick < 96) begin
      act = ACT_XLATE;
      if ($urandom_range(99) < 85) begin
        va[31:20] = hot_l1[$urandom_range(7)];
        va[19:12] = hot_word[$urandom_range(7)];
      end
    end else begin
      act = ACT_UNUSED;
    end
    send_item(act, idx, data, va);
  endtask

  initial begin
    int unsigned phase_idle [3];
    phase_idle = '{12, 80, 0};
    foreach (hot_l1[i]) hot_l1[i] = 12'($urandom);
    foreach (hot_tbl[i]) hot_tbl[i] = 6'($urandom);
    foreach (hot_word[i]) hot_word[i] = 8'($urandom);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The first transfer waits out the clearing pass.
    // An empty first-level entry faults.
    send_item(ACT_XLATE, 14'h0000, 32'h0, 32'h0000_0000);
    // Section at base zero.
    send_item(ACT_WR_L1, 14'h0000, 32'h0000_0002, 32'h0);
    send_item(ACT_XLATE, 14'h0, 32'h0, 32'h000a_bcde);
    // Supersection whose base plus the 24-bit offset wraps past the top.
    send_item(ACT_WR_L1, 14'h0fff, 32'hfff4_0002, 32'h0);
    send_item(ACT_XLATE, 14'h0, 32'h0, 32'hffff_ffff);
    // First-level type 3 faults even with every other bit set.
    send_item(ACT_WR_L1, 14'h0123, 32'hffff_fff3, 32'h0);
    send_item(ACT_XLATE, 14'h0, 32'h0, 32'h1234_5678);
    // Coarse descriptor with the largest table number, reduced to the last table.
    send_item(ACT_WR_L1, 14'h0800, 32'hffff_fc01, 32'h0);
    send_item(ACT_WR_POOL, 14'h3fff, 32'hffff_ffff, 32'h0);
    send_item(ACT_XLATE, 14'h0, 32'h0, 32'h800f_f123);
    // Large page, then a coarse descriptor with type 0 that faults.
    send_item(ACT_WR_POOL, 14'h3f00, 32'h1234_5001, 32'h0);
    send_item(ACT_XLATE, 14'h0, 32'h0, 32'h8000_0abc);
    send_item(ACT_WR_POOL, 14'h3f01, 32'hffff_f000, 32'h0);
    send_item(ACT_XLATE, 14'h0, 32'h0, 32'h8000_1000);
    // Coarse table 0 still holds its cleared words, so the walk faults there.
    send_item(ACT_WR_L1, 14'h0001, 32'h0000_0001, 32'h0);
    send_item(ACT_XLATE, 14'h0, 32'h0, 32'h001f_ffff);
    // A valid large page whose translation is all ones.
    send_item(ACT_WR_POOL, 14'h0000, 32'hffff_0001, 32'h0);
    send_item(ACT_XLATE, 14'h0, 32'h0, 32'h0010_ffff);
    // The unused action changes nothing and returns zeros.
    send_item(ACT_UNUSED, 14'h3fff, 32'hffff_ffff, 32'hffff_ffff);
    send_item(ACT_XLATE, 14'h0, 32'h0, 32'hfff1_2345);
    // A first-level write keeps only the low 12 bits of the index.
    send_item(ACT_WR_L1, 14'h3fff, 32'h0000_0002, 32'h0);
    send_item(ACT_XLATE, 14'h0, 32'h0, 32'hfff1_2345);
    // Small page at the very first pool word.
    send_item(ACT_WR_POOL, 14'h0000, 32'h0000_0002, 32'h0);
    send_item(ACT_XLATE, 14'h0, 32'h0, 32'h0010_0fff);

    // Random part: light sender gaps, heavy gaps, then back to back.
    foreach (phase_idle[p]) begin
      idle_pct = phase_idle[p];
      repeat (PHASE_ITEMS) send_random_item();
    end
    start <= 1'b0;

    while (walk_sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (walk_sb.failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
